/* rtl/core/snmiou_pkg.sv */
// Shared types, constants and codes for the nearest segment match block.
package snmiou_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int COORD_W      = 20;
  localparam int LIMIT_W      = 40;
  localparam int RATIO_W      = 8;
  localparam int DIST_W       = 42;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 40'd32883343;
  localparam logic [RATIO_W-1:0] NUM_RST   = 8'd3;
  localparam logic [RATIO_W-1:0] DEN_RST   = 8'd10;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_SKIP   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_NUM   = 2'd1;
  localparam logic [1:0] REG_DEN   = 2'd2;

  typedef logic [2:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    logic    vld;
    coord3_t c;
    coord3_t lo;
    coord3_t hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_DRAIN, S_OV1, S_OV2, S_OV3, S_OV4, S_OV5, S_EMIT
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic             latch_q;
    logic             skip;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             pipe_busy;
  } stat_t;

endpackage

/* rtl/core/segment_nearest_match_iou_gate_core.sv */
// Top level of the nearest segment match block with box overlap gate.
//
// A request is taken when start is high and busy is low. in_operation selects:
// clear empties the table, load appends one segment (dropped when 64 are
// stored), query searches the table. Clear and load finish in the cycle they
// are taken and give no result; busy stays low. A query with in_seg_valid low
// gives a skip result on out_strobe in the next cycle.
// A valid query walks the stored entries, one RAM read a cycle, through a
// two-stage squared-distance pipeline, then runs a five-step overlap
// multiply chain; busy is high until the result is given. The single
// table read port sets the walk length.
// Each result holds for one cycle with out_strobe high; the receiver cannot
// stall. Reset empties the table and loads register defaults; configuration
// writes via cfg_we/cfg_index/cfg_wdata take effect at once, out-of-range
// indexes are ignored.
module segment_nearest_match_iou_gate_core
  import snmiou_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic                      in_seg_valid,
  input  logic signed [COORD_W-1:0] in_centroid_x,
  input  logic signed [COORD_W-1:0] in_centroid_y,
  input  logic signed [COORD_W-1:0] in_centroid_z,
  input  logic signed [COORD_W-1:0] in_box_min_x,
  input  logic signed [COORD_W-1:0] in_box_min_y,
  input  logic signed [COORD_W-1:0] in_box_min_z,
  input  logic signed [COORD_W-1:0] in_box_max_x,
  input  logic signed [COORD_W-1:0] in_box_max_y,
  input  logic signed [COORD_W-1:0] in_box_max_z,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [LIMIT_W-1:0]        cfg_wdata,
  output logic                      out_strobe,
  output logic [1:0]                out_match_status,
  output logic [IDX_W-1:0]          out_match_index
);

  cmd_t  cmd;
  stat_t stat;

  snmiou_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_seg_valid (in_seg_valid),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  snmiou_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_seg_valid     (in_seg_valid),
    .in_centroid_x    (in_centroid_x),
    .in_centroid_y    (in_centroid_y),
    .in_centroid_z    (in_centroid_z),
    .in_box_min_x     (in_box_min_x),
    .in_box_min_y     (in_box_min_y),
    .in_box_min_z     (in_box_min_z),
    .in_box_max_x     (in_box_max_x),
    .in_box_max_y     (in_box_max_y),
    .in_box_max_z     (in_box_max_z),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_match_status (out_match_status),
    .out_match_index  (out_match_index)
  );

endmodule

/* rtl/core/snmiou_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module snmiou_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/core/snmiou_ctrl.sv */
// Controller: request decode, table walk sequencing and overlap test steps.
module snmiou_ctrl
  import snmiou_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  logic       in_seg_valid,
  input  stat_t      stat,
  output logic       busy,
  output cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start && in_operation == OP_QUERY && in_seg_valid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt_r == stat.count) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_OV1;
        end
      end
      S_OV1: state_nxt = S_OV2;
      S_OV2: state_nxt = S_OV3;
      S_OV3: state_nxt = S_OV4;
      S_OV4: state_nxt = S_OV5;
      S_OV5: state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    busy    = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.clear   = start && (in_operation == OP_CLEAR);
        cmd.load    = start && (in_operation == OP_LOAD);
        cmd.latch_q = start && (in_operation == OP_QUERY) && in_seg_valid;
        cmd.skip    = start && (in_operation == OP_QUERY) && !in_seg_valid;
      end
      S_WALK: begin
        cmd.rd_en   = (cnt_r != stat.count);
        cmd.rd_addr = cnt_r[IDX_W-1:0];
      end
      S_EMIT: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/snmiou_dp.sv */
// Datapath: segment table, distance pipeline, best tracking and overlap gate.
module snmiou_dp
  import snmiou_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic                      in_seg_valid,
  input  logic signed [COORD_W-1:0] in_centroid_x,
  input  logic signed [COORD_W-1:0] in_centroid_y,
  input  logic signed [COORD_W-1:0] in_centroid_z,
  input  logic signed [COORD_W-1:0] in_box_min_x,
  input  logic signed [COORD_W-1:0] in_box_min_y,
  input  logic signed [COORD_W-1:0] in_box_min_z,
  input  logic signed [COORD_W-1:0] in_box_max_x,
  input  logic signed [COORD_W-1:0] in_box_max_y,
  input  logic signed [COORD_W-1:0] in_box_max_z,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [LIMIT_W-1:0]        cfg_wdata,
  output logic                      out_strobe,
  output logic [1:0]                out_match_status,
  output logic [IDX_W-1:0]          out_match_index
);

  logic [LIMIT_W-1:0] limit_r;
  logic [RATIO_W-1:0] num_r, den_r;
  logic [CNT_W-1:0]   count_r;

  entry_t           wentry, rentry;
  logic [ENTRY_W-1:0] rdata;
  logic             wr_en;

  coord3_t q_c_r, q_lo_r, q_hi_r;

  logic             p1_vld_r;
  logic [IDX_W-1:0] p1_idx_r;
  logic             p2_vld_r;
  logic [IDX_W-1:0] p2_idx_r;
  logic [2:0][39:0] p2_sq_r;
  coord3_t          p2_lo_r, p2_hi_r;
  logic [DIST_W-1:0] d_sum;

  logic              found_r;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]  best_idx_r;
  coord3_t           best_lo_r, best_hi_r;

  logic signed [20:0] w_r [3];
  logic signed [20:0] da_r [3];
  logic signed [20:0] db_r [3];
  logic signed [41:0] pi_r, pa_r, pb_r;
  logic signed [62:0] inter_r, va_r, vb_r;
  logic signed [63:0] uni_r;
  logic [71:0]        lhs_r, rhs_r;
  logic               uni_pos_r;
  logic               pass;

  logic               out_strobe_r;
  logic [1:0]         out_status_r;
  logic [IDX_W-1:0]   out_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      num_r   <= NUM_RST;
      den_r   <= DEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT: limit_r <= cfg_wdata;
        REG_NUM:   num_r   <= cfg_wdata[RATIO_W-1:0];
        REG_DEN:   den_r   <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_en = cmd.load && (count_r < CNT_W'(MAX_SEGMENTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + 1'b1;
    end
  end

  assign wentry.vld = in_seg_valid;
  assign wentry.c   = {in_centroid_z, in_centroid_y, in_centroid_x};
  assign wentry.lo  = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign wentry.hi  = {in_box_max_z, in_box_max_y, in_box_max_x};

  snmiou_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wentry),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  assign rentry = entry_t'(rdata);

  always_ff @(posedge clk) begin
    if (cmd.latch_q) begin
      q_c_r  <= wentry.c;
      q_lo_r <= wentry.lo;
      q_hi_r <= wentry.hi;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cmd.rd_en;
      p2_vld_r <= p1_vld_r && rentry.vld;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [20:0] df;
    logic signed [41:0] sq;
    p1_idx_r <= cmd.rd_addr;
    p2_idx_r <= p1_idx_r;
    p2_lo_r  <= rentry.lo;
    p2_hi_r  <= rentry.hi;
    for (int k = 0; k < 3; k++) begin
      df = 21'($signed(q_c_r[k])) - 21'($signed(rentry.c[k]));
      sq = 42'(df) * 42'(df);
      p2_sq_r[k] <= sq[39:0];
    end
  end

  assign d_sum = DIST_W'(p2_sq_r[0]) + DIST_W'(p2_sq_r[1]) + DIST_W'(p2_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.latch_q) begin
      found_r <= 1'b0;
    end else if (p2_vld_r && (!found_r || d_sum < best_d_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_vld_r && (!found_r || d_sum < best_d_r)) begin
      best_d_r   <= d_sum;
      best_idx_r <= p2_idx_r;
      best_lo_r  <= p2_lo_r;
      best_hi_r  <= p2_hi_r;
    end
  end

  assign stat.count     = count_r;
  assign stat.pipe_busy = p1_vld_r || p2_vld_r;

  // overlap pipeline
  always_ff @(posedge clk) begin
    logic signed [19:0] ql, qh, bl, bh, l, h;
    logic signed [20:0] w;
    for (int k = 0; k < 3; k++) begin
      ql = $signed(q_lo_r[k]);
      qh = $signed(q_hi_r[k]);
      bl = $signed(best_lo_r[k]);
      bh = $signed(best_hi_r[k]);
      l  = (ql > bl) ? ql : bl;
      h  = (qh < bh) ? qh : bh;
      w  = 21'(h) - 21'(l);
      w_r[k]  <= w[20] ? 21'sd0 : w;
      da_r[k] <= 21'(qh) - 21'(ql);
      db_r[k] <= 21'(bh) - 21'(bl);
    end
    pi_r    <= 42'(w_r[0]) * 42'(w_r[1]);
    pa_r    <= 42'(da_r[0]) * 42'(da_r[1]);
    pb_r    <= 42'(db_r[0]) * 42'(db_r[1]);
    inter_r <= 63'(pi_r) * 63'(w_r[2]);
    va_r    <= 63'(pa_r) * 63'(da_r[2]);
    vb_r    <= 63'(pb_r) * 63'(db_r[2]);
    uni_r   <= 64'(va_r) + 64'(vb_r) - 64'(inter_r);
    lhs_r   <= 72'(inter_r[61:0]) * 72'(den_r);
    rhs_r   <= 72'(uni_r[62:0]) * 72'(num_r);
    uni_pos_r <= !uni_r[63] && (uni_r != 64'sd0);
  end

  assign pass = found_r && (best_d_r <= DIST_W'(limit_r)) &&
                (!uni_pos_r || lhs_r >= rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit || cmd.skip;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.skip) begin
      out_status_r <= ST_SKIP;
      out_index_r  <= '0;
    end else if (cmd.emit) begin
      out_status_r <= pass ? ST_MATCH : ST_REJECT;
      out_index_r  <= pass ? best_idx_r : '0;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_match_status = out_status_r;
  assign out_match_index  = out_index_r;

endmodule

/* rtl/core/snmiou_checker.sv */
// Port-level checker for the nearest segment match block, with its bind.
module snmiou_checker
  import snmiou_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_operation,
  input logic             in_seg_valid,
  input logic             out_strobe,
  input logic [1:0]       out_match_status,
  input logic [IDX_W-1:0] out_match_index
);

  a_skip_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_QUERY && !in_seg_valid
    |=> out_strobe && out_match_status == ST_SKIP)
    else $error("invalid query did not give a skip result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_QUERY && in_seg_valid |=> busy)
    else $error("valid query did not raise busy");

  a_idle_other: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_CLEAR || in_operation == OP_LOAD)
    |=> !busy && !out_strobe)
    else $error("clear or load started work or gave a result");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_match_status != ST_MATCH |-> out_match_index == '0)
    else $error("index not zero on unmatched result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_match_status == ST_SKIP || out_match_status == ST_MATCH ||
                    out_match_status == ST_REJECT))
    else $error("unknown result status");

endmodule

bind segment_nearest_match_iou_gate_core snmiou_checker u_snmiou_checker (.*);

/* test/tb_segment_nearest_match_iou_gate_core.sv */
// Testbench for the nearest segment match block: directed and random requests.
`timescale 1ns / 1ps

module tb_segment_nearest_match_iou_gate_core;
  import snmiou_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT = MAX_SEGMENTS + 20;

  typedef struct {
    logic [1:0]                op;
    logic                      sv;
    logic signed [COORD_W-1:0] c[3];
    logic signed [COORD_W-1:0] lo[3];
    logic signed [COORD_W-1:0] hi[3];
  } seg_req_t;

  class match_scoreboard;
    bit                  tbl_vld[MAX_SEGMENTS];
    longint              tbl_c[MAX_SEGMENTS][3];
    longint              tbl_lo[MAX_SEGMENTS][3];
    longint              tbl_hi[MAX_SEGMENTS][3];
    int                  count;
    bit [LIMIT_W-1:0]    dist_limit;
    bit [RATIO_W-1:0]    ratio_num;
    bit [RATIO_W-1:0]    ratio_den;
    bit [1:0]            exp_status[$];
    bit [IDX_W-1:0]      exp_index[$];
    int                  errors;

    function new();
      count = 0;
      dist_limit = LIMIT_RST;
      ratio_num = NUM_RST;
      ratio_den = DEN_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [LIMIT_W-1:0] data);
      case (idx)
        REG_LIMIT: dist_limit = data;
        REG_NUM:   ratio_num = data[RATIO_W-1:0];
        REG_DEN:   ratio_den = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function void expect_result(bit [1:0] st, bit [IDX_W-1:0] ix);
      exp_status = {exp_status, st};
      exp_index = {exp_index, ix};
    endfunction

    function bit overlap_ok(seg_req_t q, int e);
      longint inter, va, vb, uni, l, h, w;
      bit [79:0] lhs, rhs;
      inter = 1;
      va = 1;
      vb = 1;
      for (int k = 0; k < 3; k++) begin
        l = (q.lo[k] > tbl_lo[e][k]) ? q.lo[k] : tbl_lo[e][k];
        h = (q.hi[k] < tbl_hi[e][k]) ? q.hi[k] : tbl_hi[e][k];
        w = h - l;
        if (w < 0) w = 0;
        inter *= w;
        va *= longint'(q.hi[k]) - longint'(q.lo[k]);
        vb *= tbl_hi[e][k] - tbl_lo[e][k];
      end
      uni = va + vb - inter;
      if (uni <= 0) return 1;
      lhs = 80'(inter) * 80'(ratio_den);
      rhs = 80'(uni) * 80'(ratio_num);
      return lhs >= rhs;
    endfunction

    function void note_request(seg_req_t q);
      bit found;
      int best;
      longint unsigned best_d, d;
      longint df;
      case (q.op)
        OP_CLEAR: count = 0;
        OP_LOAD: begin
          if (count < MAX_SEGMENTS) begin
            tbl_vld[count] = q.sv;
            for (int k = 0; k < 3; k++) begin
              tbl_c[count][k] = q.c[k];
              tbl_lo[count][k] = q.lo[k];
              tbl_hi[count][k] = q.hi[k];
            end
            count++;
          end
        end
        OP_QUERY: begin
          if (!q.sv) begin
            expect_result(ST_SKIP, '0);
          end else begin
            found = 0;
            best = 0;
            best_d = 0;
            for (int i = 0; i < count; i++) begin
              if (tbl_vld[i]) begin
                d = 0;
                for (int k = 0; k < 3; k++) begin
                  df = longint'(q.c[k]) - tbl_c[i][k];
                  d += df * df;
                end
                if (!found || d < best_d) begin
                  found = 1;
                  best_d = d;
                  best = i;
                end
              end
            end
            if (!found || best_d > dist_limit || !overlap_ok(q, best)) begin
              expect_result(ST_REJECT, '0);
            end else begin
              expect_result(ST_MATCH, best[IDX_W-1:0]);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [IDX_W-1:0] ix);
      bit [1:0] es;
      bit [IDX_W-1:0] ei;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status %0d index %0d", $time, st, ix);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ei = exp_index.pop_front();
      if (st !== es) begin
        $display("%0t: match_status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (ix !== ei) begin
        $display("%0t: match_index expected %0d actual %0d", $time, ei, ix);
        errors++;
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_operation;
  logic                      in_seg_valid;
  logic signed [COORD_W-1:0] in_centroid_x, in_centroid_y, in_centroid_z;
  logic signed [COORD_W-1:0] in_box_min_x, in_box_min_y, in_box_min_z;
  logic signed [COORD_W-1:0] in_box_max_x, in_box_max_y, in_box_max_z;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [LIMIT_W-1:0]        cfg_wdata;
  logic                      out_strobe;
  logic [1:0]                out_match_status;
  logic [IDX_W-1:0]          out_match_index;

  match_scoreboard sb;
  int cycles = 0;
  int idle_pct;
  int gen_count;
  seg_req_t loaded[MAX_SEGMENTS];

  segment_nearest_match_iou_gate_core dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_seg_valid,
    .in_centroid_x, .in_centroid_y, .in_centroid_z,
    .in_box_min_x, .in_box_min_y, .in_box_min_z,
    .in_box_max_x, .in_box_max_y, .in_box_max_z,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_strobe, .out_match_status, .out_match_index
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    seg_req_t q;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_match_status, out_match_index);
      if (start && !busy) begin
        q.op = in_operation;
        q.sv = in_seg_valid;
        q.c = '{in_centroid_x, in_centroid_y, in_centroid_z};
        q.lo = '{in_box_min_x, in_box_min_y, in_box_min_z};
        q.hi = '{in_box_max_x, in_box_max_y, in_box_max_z};
        sb.note_request(q);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp20(longint v);
    if (v > 524287) return COORD_W'(524287);
    if (v < -524288) return COORD_W'(-524288);
    return v[COORD_W-1:0];
  endfunction

  function automatic seg_req_t make_req(logic [1:0] op, logic sv, longint cx, longint cy,
                                        longint cz, longint ext);
    seg_req_t q;
    longint cc[3];
    cc = '{cx, cy, cz};
    q.op = op;
    q.sv = sv;
    for (int k = 0; k < 3; k++) begin
      q.c[k] = clamp20(cc[k]);
      q.lo[k] = clamp20(cc[k] - ext);
      q.hi[k] = clamp20(cc[k] + ext);
    end
    return q;
  endfunction

  function automatic seg_req_t noise_req();
    seg_req_t q;
    q.op = 2'($urandom_range(3));
    q.sv = 1'($urandom_range(1));
    for (int k = 0; k < 3; k++) begin
      q.c[k] = COORD_W'($urandom);
      q.lo[k] = COORD_W'($urandom);
      q.hi[k] = COORD_W'($urandom);
    end
    return q;
  endfunction

  task automatic send(seg_req_t q);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_operation = q.op;
    in_seg_valid = q.sv;
    {in_centroid_x, in_centroid_y, in_centroid_z} = {q.c[0], q.c[1], q.c[2]};
    {in_box_min_x, in_box_min_y, in_box_min_z} = {q.lo[0], q.lo[1], q.lo[2]};
    {in_box_max_x, in_box_max_y, in_box_max_z} = {q.hi[0], q.hi[1], q.hi[2]};
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (q.op == OP_CLEAR) gen_count = 0;
    if (q.op == OP_LOAD && gen_count < MAX_SEGMENTS) begin
      loaded[gen_count] = q;
      gen_count++;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [LIMIT_W-1:0] data);
    @(negedge clk);
    start = 0;
    while (sb.pending() > 0 || busy) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_seg(logic sv, longint cx, longint cy, longint cz, longint ext);
    send(make_req(OP_LOAD, sv, cx, cy, cz, ext));
  endtask

  task automatic query_seg(logic sv, longint cx, longint cy, longint cz, longint ext);
    send(make_req(OP_QUERY, sv, cx, cy, cz, ext));
  endtask

  task automatic run_directed();
    seg_req_t q;
    query_seg(1, 0, 0, 0, 100);
    query_seg(0, 0, 0, 0, 100);
    send(make_req(OP_UNUSED, 1, 5, 5, 5, 10));
    load_seg(0, -524288, -524288, -524288, 0);
    q = make_req(OP_LOAD, 1, 524287, 524287, 524287, 0);
    q.lo = '{COORD_W'(-524288), COORD_W'(-524288), COORD_W'(-524288)};
    send(q);
    q.op = OP_QUERY;
    q.c = '{COORD_W'(-524288), COORD_W'(-524288), COORD_W'(-524288)};
    send(q);
    write_reg(REG_LIMIT, '1);
    send(q);
    q = make_req(OP_LOAD, 1, 0, 0, 0, 0);
    q.lo = '{COORD_W'(10), COORD_W'(10), COORD_W'(-10)};
    q.hi = '{COORD_W'(-10), COORD_W'(-10), COORD_W'(10)};
    send(q);
    q.op = OP_QUERY;
    send(q);
    write_reg(REG_NUM, LIMIT_W'(255));
    write_reg(REG_DEN, LIMIT_W'(0));
    load_seg(1, 100000, 0, 0, 2000);
    query_seg(1, 100000, 0, 0, 2000);
    write_reg(REG_NUM, LIMIT_W'(0));
    query_seg(1, 100100, 0, 0, 1500);
    write_reg(REG_DEN, LIMIT_W'(255));
    write_reg(REG_NUM, LIMIT_W'(1));
    send(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < MAX_SEGMENTS + 2; i++) load_seg(1, i * 8000, 0, 0, 1000);
    query_seg(1, 63 * 8000, 0, 0, 1000);
    query_seg(1, 66 * 8000, 0, 0, 1000);
  endtask

  task automatic run_random(int n_items);
    int sent, n, j;
    seg_req_t q;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send(noise_req());
        sent++;
      end else begin
        if ($urandom_range(2) == 0) begin
          send(make_req(OP_CLEAR, 1'($urandom_range(1)), 0, 0, 0, 0));
          sent++;
        end
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          load_seg($urandom_range(99) < 85,
                   $signed($urandom_range(200000)) - 100000,
                   $signed($urandom_range(200000)) - 100000,
                   $signed($urandom_range(200000)) - 100000,
                   longint'($urandom_range(4000)));
          sent++;
        end
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if (gen_count > 0 && $urandom_range(9) < 8) begin
            j = $urandom_range(gen_count - 1);
            q = loaded[j];
            q.op = OP_QUERY;
            q.sv = $urandom_range(9) != 0;
            for (int k = 0; k < 3; k++) begin
              q.c[k] = clamp20(longint'(q.c[k]) + $signed($urandom_range(6000)) - 3000);
              q.lo[k] = clamp20(longint'(q.lo[k]) + $signed($urandom_range(3000)) - 1500);
              q.hi[k] = clamp20(longint'(q.hi[k]) + $signed($urandom_range(3000)) - 1500);
            end
            send(q);
          end else begin
            query_seg($urandom_range(9) != 0, $signed($urandom_range(200000)) - 100000,
                      $signed($urandom_range(200000)) - 100000, 0,
                      longint'($urandom_range(4000)));
          end
          sent++;
        end
      end
    end
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(REG_LIMIT, LIMIT_RST);
      1: write_reg(REG_LIMIT, LIMIT_W'({$urandom_range(255), $urandom}));
      2: write_reg(REG_LIMIT, LIMIT_W'($urandom_range(40000000)));
      default: write_reg(REG_LIMIT, '0);
    endcase
    write_reg(REG_NUM, LIMIT_W'($urandom_range(255)));
    write_reg(REG_DEN, ($urandom_range(9) == 0) ? LIMIT_W'(0) :
                       LIMIT_W'($urandom_range(1, 255)));
  endtask

  initial begin
    sb = new();
    gen_count = 0;
    idle_pct = 0;
    rst_n = 0;
    start = 0;
    in_operation = OP_CLEAR;
    in_seg_valid = 0;
    {in_centroid_x, in_centroid_y, in_centroid_z} = '0;
    {in_box_min_x, in_box_min_y, in_box_min_z} = '0;
    {in_box_max_x, in_box_max_y, in_box_max_z} = '0;
    cfg_we = 0;
    cfg_index = REG_LIMIT;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    idle_pct = 33;
    run_directed();
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 33 : (p == 1) ? 64 : 0;
      for (int s = 0; s < 3; s++) begin
        if (p == 2 && s == 0) begin
          write_reg(REG_LIMIT, LIMIT_RST);
          write_reg(REG_NUM, LIMIT_W'(NUM_RST));
          write_reg(REG_DEN, LIMIT_W'(DEN_RST));
        end else begin
          random_config();
        end
        run_random(200);
      end
    end
    @(negedge clk);
    start = 0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
